@@ rtl/pnfb_pkg.sv @@
package pnfb_pkg;

    // Default geometry of the store
    localparam int PNFB_MAX_WIDTH  = 256;
    localparam int PNFB_MAX_HEIGHT = 128;

    // Port field widths
    localparam int OPCODE_W     = 2;
    localparam int POS_W        = 16;
    localparam int PIXEL_W      = 8;
    localparam int NIBBLE_W     = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int WIDTH_REG_W  = 9;
    localparam int HEIGHT_REG_W = 8;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_FILL = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DRAW = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_FILL,
        ST_DRAW,
        ST_READ
    } t_state;

endpackage

@@ rtl/packed_nibble_framebuffer_top.sv @@
// Channel     | Ports                                             | Handshake
// ------------+---------------------------------------------------+--------------------------
// request in  | i_opcode, i_pos_x, i_pos_y, i_pixel_value         | taken when start && !busy
// result out  | o_read_value                                      | o_valid, one-cycle strobe
// config      | i_cfg_we, i_cfg_index, i_cfg_wdata                | written when i_cfg_we
//
// Sequence: a read passes the check and read states and its o_valid strobe is
// registered from the read state; a draw passes check (byte read) and draw (merged
// write-back), or leaves check for idle when it falls outside the surface, as does
// an unused opcode. A fill passes check, then (unless empty) writes rows * bytes-per-row
// bytes, one byte per cycle. Reset: the block sweeps the store to zero, one byte per
// cycle, MAX_WIDTH * MAX_HEIGHT bytes (32768 default), busy high. The receiver cannot stall.
module packed_nibble_framebuffer_top
    import pnfb_pkg::*;
#(
    parameter int MAX_WIDTH  = PNFB_MAX_WIDTH,
    parameter int MAX_HEIGHT = PNFB_MAX_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request
    input  logic                   start,
    output logic                   busy,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [POS_W-1:0]       i_pos_x,
    input  logic [POS_W-1:0]       i_pos_y,
    input  logic [PIXEL_W-1:0]     i_pixel_value,
    // result
    output logic                   o_valid,
    output logic [NIBBLE_W-1:0]    o_read_value,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    // width of the clamped row length and row count (they may equal the maximum)
    localparam int UW    = $clog2(MAX_WIDTH + 1);
    localparam int HUW   = $clog2(MAX_HEIGHT + 1);
    // byte column and row index widths
    localparam int CIW   = $clog2(MAX_WIDTH);
    localparam int RIW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

    // Sequencer state
    t_state r_state;
    t_state n_state;

    // Configuration, held already clamped to the store geometry
    logic [UW-1:0]  r_width_used;
    logic [HUW-1:0] r_height_used;
    logic           r_depth_mode;

    // Captured request
    logic [OPCODE_W-1:0] r_op;
    logic [POS_W-1:0]    r_x;
    logic [POS_W-1:0]    r_y;
    logic [PIXEL_W-1:0]  r_v;

    // Address unit and fill walk
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_base;
    logic [CIW-1:0]     r_col;
    logic [RIW-1:0]     r_row;
    logic [UW-1:0]      r_last_col;
    logic [PIXEL_W-1:0] r_fill_byte;
    logic               r_rd_ok;

    // Result register
    logic                r_out_valid;
    logic [NIBBLE_W-1:0] r_read_value;

    // Combinational helpers
    logic               in_range;
    logic [AW-1:0]      addr_calc;
    logic [UW:0]        w_plus;
    logic [UW-1:0]      fill_bytes;
    logic               fill_empty;
    logic               row_end;
    logic               fill_last;
    logic               clear_last;
    logic [PIXEL_W-1:0] rdata;
    logic [NIBBLE_W-1:0] rd_nibble;

    // RAM controls
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [PIXEL_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;

    pnfb_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    // Bounds check and byte address of the captured pixel. Only the low bits
    // are used: when the pixel is inside the surface they hold it whole.
    always_comb begin
        in_range  = (r_x < POS_W'(r_width_used)) && (r_y < POS_W'(r_height_used));
        addr_calc = AW'(r_y[RIW-1:0]) * ROW_STRIDE + AW'(r_x[CIW:1]);
    end

    // Bytes per row: width in 8-bit mode, ceil(width/2) in 4-bit mode
    always_comb begin
        w_plus     = {1'b0, r_width_used} + (UW+1)'(1);
        fill_bytes = r_depth_mode ? r_width_used : w_plus[UW:1];
        fill_empty = (r_height_used == '0) || (fill_bytes == '0);
    end

    always_comb begin
        row_end    = (UW'(r_col) == r_last_col);
        fill_last  = row_end && (HUW'(r_row) == (r_height_used - HUW'(1)));
        clear_last = (r_addr == LAST_ADDR);
        // even x sits in the high nibble, odd x in the low nibble
        rd_nibble  = r_x[0] ? rdata[NIBBLE_W-1:0] : rdata[PIXEL_W-1:NIBBLE_W];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                case (r_op)
                    OP_FILL: n_state = fill_empty ? ST_IDLE : ST_FILL;
                    OP_DRAW: n_state = in_range ? ST_DRAW : ST_IDLE;
                    OP_READ: n_state = ST_READ;
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_FILL: begin
                if (fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAW: n_state = ST_IDLE;
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM port controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        mem_raddr = addr_calc;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = r_fill_byte;
            end
            ST_DRAW: begin
                // merge the new brightness into the byte read during check
                mem_we = 1'b1;
                if (r_x[0]) begin
                    mem_wdata = {rdata[PIXEL_W-1:NIBBLE_W], r_v[NIBBLE_W-1:0]};
                end else begin
                    mem_wdata = {r_v[NIBBLE_W-1:0], rdata[NIBBLE_W-1:0]};
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_out_valid   <= 1'b0;
            r_width_used  <= '0;
            r_height_used <= '0;
            r_depth_mode  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == ST_READ);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH: begin
                        // clamp an oversized width to the row length of the store
                        if (POS_W'(i_cfg_wdata[WIDTH_REG_W-1:0]) > POS_W'(MAX_WIDTH)) begin
                            r_width_used <= UW'(MAX_WIDTH);
                        end else begin
                            r_width_used <= UW'(POS_W'(i_cfg_wdata[WIDTH_REG_W-1:0]));
                        end
                    end
                    CFG_HEIGHT: begin
                        if (POS_W'(i_cfg_wdata[HEIGHT_REG_W-1:0]) > POS_W'(MAX_HEIGHT)) begin
                            r_height_used <= HUW'(MAX_HEIGHT);
                        end else begin
                            r_height_used <= HUW'(POS_W'(i_cfg_wdata[HEIGHT_REG_W-1:0]));
                        end
                    end
                    CFG_DEPTH: begin
                        r_depth_mode <= i_cfg_wdata[0];
                    end
                    default: begin
                        r_depth_mode <= r_depth_mode;
                    end
                endcase
            end
        end
    end

    // Walk address: cleared by reset so the clearing sweep starts at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: r_addr <= r_addr + AW'(1);
                ST_CHECK: r_addr <= (r_op == OP_FILL) ? '0 : addr_calc;
                ST_FILL: begin
                    // advance along the row, or jump to the start of the next row
                    r_addr <= row_end ? (r_base + ROW_STRIDE) : (r_addr + AW'(1));
                end
                default: r_addr <= r_addr;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && start) begin
            r_op <= i_opcode;
            r_x  <= i_pos_x;
            r_y  <= i_pos_y;
            r_v  <= i_pixel_value;
        end
        case (r_state)
            ST_CHECK: begin
                r_base      <= '0;
                r_col       <= '0;
                r_row       <= '0;
                r_last_col  <= fill_bytes - UW'(1);
                r_fill_byte <= r_depth_mode ? r_v
                                            : {r_v[NIBBLE_W-1:0], r_v[NIBBLE_W-1:0]};
                r_rd_ok     <= in_range && !r_depth_mode;
            end
            ST_FILL: begin
                if (row_end) begin
                    r_col  <= '0;
                    r_row  <= r_row + RIW'(1);
                    r_base <= r_base + ROW_STRIDE;
                end else begin
                    r_col <= r_col + CIW'(1);
                end
            end
            ST_READ: begin
                // outside the surface or in 8-bit mode a read returns zero
                r_read_value <= r_rd_ok ? rd_nibble : '0;
            end
            default: begin
                r_rd_ok <= r_rd_ok;
            end
        endcase
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;

endmodule

@@ rtl/pnfb_mem.sv @@
module pnfb_mem
    import pnfb_pkg::*;
#(
    parameter int DEPTH = PNFB_MAX_WIDTH * PNFB_MAX_HEIGHT,
    parameter int AW    = $clog2(PNFB_MAX_WIDTH * PNFB_MAX_HEIGHT)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [PIXEL_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [PIXEL_W-1:0] o_rdata
);

    logic [PIXEL_W-1:0] r_mem [DEPTH];
    logic [PIXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pnfb_checker.sv @@
module pnfb_checker
    import pnfb_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [OPCODE_W-1:0] i_opcode,
    input logic                o_valid
);

    // every taken read is followed by its result strobe
    a_read_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_READ)) |-> ##3 o_valid
    ) else $error("read request produced no result");

    // no result without an earlier taken read
    a_result_from_read: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_opcode == OP_READ), 3)
    ) else $error("result strobe without a read request");

    // a read finishes before its result is shown
    a_idle_at_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy
    ) else $error("busy while a result is shown");

    // a taken request always makes the block busy in the next cycle
    a_busy_after_take: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy
    ) else $error("request taken but block not busy");

endmodule

bind packed_nibble_framebuffer_top pnfb_checker u_pnfb_checker (.*);
